[rtl/core/ppc_pkg.sv]
// Shared types and constants for the procedural pattern colour block
package ppc_pkg;

  localparam int COORD_W    = 32;
  localparam int COLOR_W    = 16;
  localparam int NUDGE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CHAN   = 3;

  localparam int SQRT_STEPS = COORD_W;
  localparam int RAD_W      = 2 * COORD_W;
  localparam int REM_W      = COORD_W + 4;

  typedef enum logic [1:0] {
    MODE_STRIPE   = 2'd0,
    MODE_GRADIENT = 2'd1,
    MODE_RING     = 2'd2,
    MODE_CHECKER  = 2'd3
  } pattern_mode_t;

  typedef logic [NUM_CHAN-1:0][COLOR_W-1:0] rgb_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_RED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_GREEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_RED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_GREEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_BLUE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NUDGE        = 3'd7;

  localparam logic [COLOR_W-1:0] FIRST_RST  = 16'd16384;
  localparam logic [COLOR_W-1:0] SECOND_RST = 16'd0;
  localparam logic [NUDGE_W-1:0] NUDGE_RST  = 16'd655;

endpackage

[rtl/core/procedural_pattern_color.sv]
// Procedural pattern colour: stripe, gradient, ring and checker texture pipeline
// A beat passes stages 0 to 2, the square root stages and then the output register.
// Throughput: one beat per cycle while in_ready is high; the ring radius comes from a
// 32-stage square root, one root bit per stage, with two squarers and the blend in front.
// A one-entry skid stage behind the output register keeps in_ready a registered signal.
// Reset (rst_n low, synchronous) clears all valid bits and the skid, and loads the
// configuration registers with their default values; data registers keep their contents.
module procedural_pattern_color
  import ppc_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_W-1:0]    out_red,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_blue
);

  localparam int FRAC_W  = COORD_FRAC_BITS;
  localparam int BLEND_W = COLOR_W + FRAC_W + 1;
  localparam int ACC_W   = BLEND_W + 1;
  localparam int NUM_STG = SQRT_STEPS + 4;
  localparam int LAST    = NUM_STG - 1;
  localparam logic [FRAC_W:0]    ONE_F  = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [ACC_W-1:0]   HALF_F = ACC_W'(1 << (FRAC_W - 1));

  // configuration
  pattern_mode_t        mode_r;
  rgb_t                 col_a_r;
  rgb_t                 col_b_r;
  logic [NUDGE_W-1:0]   nudge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STRIPE;
      col_a_r <= {NUM_CHAN{FIRST_RST}};
      col_b_r <= {NUM_CHAN{SECOND_RST}};
      nudge_r <= NUDGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode_r     <= pattern_mode_t'(cfg_wdata[1:0]);
        REG_FIRST_RED:    col_a_r[0] <= cfg_wdata;
        REG_FIRST_GREEN:  col_a_r[1] <= cfg_wdata;
        REG_FIRST_BLUE:   col_a_r[2] <= cfg_wdata;
        REG_SECOND_RED:   col_b_r[0] <= cfg_wdata;
        REG_SECOND_GREEN: col_b_r[1] <= cfg_wdata;
        REG_SECOND_BLUE:  col_b_r[2] <= cfg_wdata;
        REG_NUDGE:        nudge_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // flow control
  logic [NUM_STG-1:0] v_r;
  logic               skid_v_r;
  logic               skid_v_nxt;
  rgb_t               skid_col_r;
  rgb_t               o_col_r;
  logic               en;

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_comb begin
    if (skid_v_r) begin
      skid_v_nxt = !out_ready;
    end else begin
      skid_v_nxt = v_r[LAST] && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
      if (en) begin
        v_r <= {v_r[NUM_STG-2:0], in_valid};
      end
    end
  end

  // stage 0: magnitudes, linear parities, fraction
  function automatic logic sat_parity(input logic [COORD_W-1:0] c,
                                      input logic [NUDGE_W-1:0] nudge);
    logic [COORD_W:0] sum;
    sum = {c[COORD_W-1], c} + (COORD_W+1)'(nudge);
    if (!sum[COORD_W] && sum[COORD_W-1]) begin
      sat_parity = 1'b1;
    end else begin
      sat_parity = sum[FRAC_W];
    end
  endfunction

  logic [COORD_W-1:0] mx_c, mz_c;
  logic               odd_lin_c;
  logic [COORD_W-1:0] s0_mx_r, s0_mz_r;
  logic               s0_odd_r;
  logic [FRAC_W-1:0]  s0_frac_r;

  assign mx_c = in_coord_x[COORD_W-1] ? (~in_coord_x + 1'b1) : in_coord_x;
  assign mz_c = in_coord_z[COORD_W-1] ? (~in_coord_z + 1'b1) : in_coord_z;

  always_comb begin
    case (mode_r)
      MODE_STRIPE:  odd_lin_c = in_coord_x[FRAC_W];
      MODE_CHECKER: odd_lin_c = sat_parity(in_coord_x, nudge_r) ^
                                sat_parity(in_coord_y, nudge_r) ^
                                sat_parity(in_coord_z, nudge_r);
      default:      odd_lin_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mx_r   <= mx_c;
      s0_mz_r   <= mz_c;
      s0_odd_r  <= odd_lin_c;
      s0_frac_r <= in_coord_x[FRAC_W-1:0];
    end
  end

  // stage 1: squares and blend products
  logic [FRAC_W:0]    wa_c;
  logic [RAD_W-1:0]   s1_sqx_r, s1_sqz_r;
  logic [BLEND_W-1:0] s1_pa_r [NUM_CHAN];
  logic [BLEND_W-1:0] s1_pb_r [NUM_CHAN];
  logic               s1_odd_r;

  assign wa_c = ONE_F - {1'b0, s0_frac_r};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqx_r <= RAD_W'(s0_mx_r) * RAD_W'(s0_mx_r);
      s1_sqz_r <= RAD_W'(s0_mz_r) * RAD_W'(s0_mz_r);
      for (int c = 0; c < NUM_CHAN; c++) begin
        s1_pa_r[c] <= BLEND_W'(col_a_r[c]) * BLEND_W'(wa_c);
        s1_pb_r[c] <= BLEND_W'(col_b_r[c]) * BLEND_W'(s0_frac_r);
      end
      s1_odd_r <= s0_odd_r;
    end
  end

  // stage 2: radicand and rounded blend
  logic [ACC_W-1:0] acc_c [NUM_CHAN];
  logic [RAD_W-1:0] s2_rad_r;
  rgb_t             s2_blend_r;
  logic             s2_odd_r;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc_c[c] = ACC_W'(s1_pa_r[c]) + ACC_W'(s1_pb_r[c]) + HALF_F;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rad_r <= s1_sqx_r + s1_sqz_r;
      for (int c = 0; c < NUM_CHAN; c++) begin
        s2_blend_r[c] <= acc_c[c][FRAC_W+COLOR_W-1:FRAC_W];
      end
      s2_odd_r <= s1_odd_r;
    end
  end

  // square root: one root bit per stage
  logic [REM_W-1:0]      sq_rem_r   [SQRT_STEPS];
  logic [COORD_W-1:0]    sq_root_r  [SQRT_STEPS];
  logic [RAD_W-1:0]      sq_rad_r   [SQRT_STEPS];
  rgb_t                  sq_blend_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_odd_r;

  logic [REM_W-1:0]      prv_rem   [SQRT_STEPS];
  logic [COORD_W-1:0]    prv_root  [SQRT_STEPS];
  logic [RAD_W-1:0]      prv_rad   [SQRT_STEPS];
  rgb_t                  prv_blend [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] prv_odd;
  logic [REM_W-1:0]      sh_rem    [SQRT_STEPS];
  logic [REM_W-1:0]      trial     [SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        prv_rem[k]   = '0;
        prv_root[k]  = '0;
        prv_rad[k]   = s2_rad_r;
        prv_blend[k] = s2_blend_r;
        prv_odd[k]   = s2_odd_r;
      end else begin
        prv_rem[k]   = sq_rem_r[k-1];
        prv_root[k]  = sq_root_r[k-1];
        prv_rad[k]   = sq_rad_r[k-1];
        prv_blend[k] = sq_blend_r[k-1];
        prv_odd[k]   = sq_odd_r[k-1];
      end
      sh_rem[k] = {prv_rem[k][REM_W-3:0], prv_rad[k][RAD_W-1:RAD_W-2]};
      trial[k]  = REM_W'({prv_root[k], 2'b01});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        if (sh_rem[k] >= trial[k]) begin
          sq_rem_r[k]  <= sh_rem[k] - trial[k];
          sq_root_r[k] <= {prv_root[k][COORD_W-2:0], 1'b1};
        end else begin
          sq_rem_r[k]  <= sh_rem[k];
          sq_root_r[k] <= {prv_root[k][COORD_W-2:0], 1'b0};
        end
        sq_rad_r[k]   <= {prv_rad[k][RAD_W-3:0], 2'b00};
        sq_blend_r[k] <= prv_blend[k];
      end
      sq_odd_r <= prv_odd;
    end
  end

  // output stage: ring parity and colour select
  logic [COORD_W:0] ring_sum_c;
  logic             odd_c;
  rgb_t             col_c;

  assign ring_sum_c = {1'b0, sq_root_r[SQRT_STEPS-1]} + (COORD_W+1)'(nudge_r);

  always_comb begin
    case (mode_r)
      MODE_RING: odd_c = ring_sum_c[FRAC_W];
      default:   odd_c = sq_odd_r[SQRT_STEPS-1];
    endcase
    if (mode_r == MODE_GRADIENT) begin
      col_c = sq_blend_r[SQRT_STEPS-1];
    end else if (odd_c) begin
      col_c = col_b_r;
    end else begin
      col_c = col_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_col_r    <= col_c;
      skid_col_r <= o_col_r;
    end
  end

  assign out_valid = skid_v_r || v_r[LAST];
  assign out_red   = skid_v_r ? skid_col_r[0] : o_col_r[0];
  assign out_green = skid_v_r ? skid_col_r[1] : o_col_r[1];
  assign out_blue  = skid_v_r ? skid_col_r[2] : o_col_r[2];

endmodule

[rtl/core/ppc_checker.sv]
// Port-level checks for the procedural pattern colour block, bound to its top level
module ppc_checker
  import ppc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] out_red,
  input logic [COLOR_W-1:0] out_green,
  input logic [COLOR_W-1:0] out_blue
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
                                $stable(out_green) && $stable(out_blue))
    else $error("stalled result beat changed");

  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("input stall held after result beat taken");

endmodule

bind procedural_pattern_color ppc_checker u_ppc_checker (.*);

[tb/ppc_colour_checker.sv]
// Scoreboard for the procedural pattern colour block: predicts each colour beat and compares it
module ppc_colour_checker
  import ppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  input  logic [COORD_W-1:0]    in_coord_z,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [COLOR_W-1:0]    out_red,
  input  logic [COLOR_W-1:0]    out_green,
  input  logic [COLOR_W-1:0]    out_blue,
  output int                    errors,
  output int                    pending,
  output int                    compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } colour_t;

  pattern_mode_t      mode;
  colour_t            first_col;
  colour_t            second_col;
  colour_t            want;
  logic [NUDGE_W-1:0] nudge;
  colour_t            colour_queue [$];
  int                 fails = 0;
  int                 seen = 0;

  function automatic logic [COLOR_W-1:0] blend(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b,
                                               logic [FRAC_BITS-1:0] f);
    logic [63:0] acc;
    acc = 64'(a) * ((64'd1 << FRAC_BITS) - 64'(f)) + 64'(b) * 64'(f)
        + (64'd1 << (FRAC_BITS - 1));
    return acc[FRAC_BITS +: COLOR_W];
  endfunction

  function automatic colour_t paint(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                    logic [COORD_W-1:0] z);
    logic signed [63:0] axis [3];
    logic signed [63:0] v;
    logic [63:0]        mx;
    logic [63:0]        mz;
    logic [63:0]        sq;
    logic [63:0]        root;
    logic [63:0]        trial;
    logic               odd;
    colour_t            c;
    axis[0] = $signed(x);
    axis[1] = $signed(y);
    axis[2] = $signed(z);
    odd = 1'b0;
    case (mode)
      MODE_GRADIENT: begin
        c.red   = blend(first_col.red, second_col.red, x[FRAC_BITS-1:0]);
        c.green = blend(first_col.green, second_col.green, x[FRAC_BITS-1:0]);
        c.blue  = blend(first_col.blue, second_col.blue, x[FRAC_BITS-1:0]);
        return c;
      end
      MODE_STRIPE: odd = x[FRAC_BITS];
      MODE_RING: begin
        mx = axis[0][63] ? -axis[0] : axis[0];
        mz = axis[2][63] ? -axis[2] : axis[2];
        sq = mx * mx + mz * mz;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= sq) root = trial;
        end
        root = root + 64'(nudge);
        odd = root[FRAC_BITS];
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          v = axis[i] + $signed({48'd0, nudge});
          if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
          odd ^= v[FRAC_BITS];
        end
      end
    endcase
    return odd ? second_col : first_col;
  endfunction

  task automatic report(string what, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] wanted);
    fails++;
    $display("[%0t] %s: got %h, expected %h", $time, what, got, wanted);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode       = MODE_STRIPE;
      first_col  = {3{FIRST_RST}};
      second_col = {3{SECOND_RST}};
      nudge      = NUDGE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:         mode = pattern_mode_t'(cfg_wdata[1:0]);
          REG_FIRST_RED:    first_col.red = cfg_wdata;
          REG_FIRST_GREEN:  first_col.green = cfg_wdata;
          REG_FIRST_BLUE:   first_col.blue = cfg_wdata;
          REG_SECOND_RED:   second_col.red = cfg_wdata;
          REG_SECOND_GREEN: second_col.green = cfg_wdata;
          REG_SECOND_BLUE:  second_col.blue = cfg_wdata;
          REG_NUDGE:        nudge = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) colour_queue.push_back(paint(in_coord_x, in_coord_y, in_coord_z));
      if (out_valid && out_ready) begin
        if (colour_queue.size() == 0) begin
          report("colour beat with nothing expected", out_red, '0);
        end else begin
          want = colour_queue.pop_front();
          seen++;
          if (out_red !== want.red) report("red mismatch", out_red, want.red);
          if (out_green !== want.green) report("green mismatch", out_green, want.green);
          if (out_blue !== want.blue) report("blue mismatch", out_blue, want.blue);
        end
      end
    end
    errors   <= fails;
    pending  <= colour_queue.size();
    compared <= seen;
  end

endmodule

[tb/tb.sv]
// Testbench top for the procedural pattern colour block: stimulus, register settings and verdict
module tb;
  import ppc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [COORD_W-1:0] in_coord_z;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COLOR_W-1:0]        out_red;
  logic [COLOR_W-1:0]        out_green;
  logic [COLOR_W-1:0]        out_blue;
  int                        errors;
  int                        pending;
  int                        compared;

  logic [CFG_DATA_W-1:0]     setting [8];
  logic                      steady = 1'b0;
  int                        beats = 0;
  int                        loads = 0;

  procedural_pattern_color DUT (.*);

  ppc_colour_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_beat(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apply(pattern_mode_t m,
                       logic [COLOR_W-1:0] ar, logic [COLOR_W-1:0] ag, logic [COLOR_W-1:0] ab,
                       logic [COLOR_W-1:0] br, logic [COLOR_W-1:0] bg, logic [COLOR_W-1:0] bb,
                       logic [NUDGE_W-1:0] nu);
    drain();
    setting[REG_MODE]         = {14'($urandom), m};
    setting[REG_FIRST_RED]    = ar;
    setting[REG_FIRST_GREEN]  = ag;
    setting[REG_FIRST_BLUE]   = ab;
    setting[REG_SECOND_RED]   = br;
    setting[REG_SECOND_GREEN] = bg;
    setting[REG_SECOND_BLUE]  = bb;
    setting[REG_NUDGE]        = nu;
    for (int i = REG_MODE; i <= REG_NUDGE; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= setting[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    loads++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    logic [COORD_W-1:0] whole;
    logic [COORD_W-1:0] nu;
    nu = {16'd0, setting[REG_NUDGE]};
    whole = ($urandom_range(0, 64) - 32'd32) << 16;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return whole | $urandom_range(0, 16'hFFFF);
      3: begin
        case ($urandom_range(0, 5))
          0: return whole;
          1: return whole - 1;
          2: return whole + 1;
          3: return whole - nu;
          4: return whole - nu - 1;
          default: return whole - nu + 1;
        endcase
      end
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          3: return '1;
          default: return 32'h7FFF_FFFF - nu + $urandom_range(0, 2) - 1;
        endcase
      end
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  initial begin
    pattern_mode_t      m;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [NUDGE_W-1:0] nu;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_MODE;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_coord_x <= '0;
    in_coord_y <= '0;
    in_coord_z <= '0;
    setting[REG_MODE]         = MODE_STRIPE;
    setting[REG_FIRST_RED]    = FIRST_RST;
    setting[REG_FIRST_GREEN]  = FIRST_RST;
    setting[REG_FIRST_BLUE]   = FIRST_RST;
    setting[REG_SECOND_RED]   = SECOND_RST;
    setting[REG_SECOND_GREEN] = SECOND_RST;
    setting[REG_SECOND_BLUE]  = SECOND_RST;
    setting[REG_NUDGE]        = NUDGE_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stripe under reset colours: floor parity either side of zero and at the extremes
    send_beat(32'h0000_0000, $urandom, $urandom);
    send_beat(32'h0001_0000, $urandom, $urandom);
    send_beat(32'hFFFF_FFFF, $urandom, $urandom);
    send_beat(32'hFFFF_0000, $urandom, $urandom);
    send_beat(32'h7FFF_FFFF, $urandom, $urandom);
    send_beat(32'h8000_0000, $urandom, $urandom);

    apply(MODE_GRADIENT, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF, 16'h1234, NUDGE_RST);
    send_beat(32'h0005_0000, $urandom, $urandom);
    send_beat(32'hFFFA_FFFF, $urandom, $urandom);
    send_beat(32'h0000_8000, $urandom, $urandom);

    apply(MODE_RING, FIRST_RST, FIRST_RST, FIRST_RST, SECOND_RST, SECOND_RST, SECOND_RST,
          NUDGE_RST);
    send_beat(32'h0000_0000, $urandom, 32'h0000_0000);
    send_beat(32'h8000_0000, $urandom, 32'h8000_0000);
    send_beat(32'h0003_0000, $urandom, 32'h0004_0000);
    send_beat(32'h0000_FDA8, $urandom, 32'h0000_0000);
    send_beat(32'h7FFF_FFFF, $urandom, 32'h8000_0000);

    apply(MODE_CHECKER, 16'h1111, 16'h2222, 16'h3333, 16'hCCCC, 16'hDDDD, 16'hEEEE, NUDGE_RST);
    send_beat(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(32'hFFFF_FD71, 32'h0000_0000, 32'h0000_0000);
    send_beat(32'h0000_FD71, 32'h0000_0000, 32'h0000_0000);
    send_beat(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);

    apply(MODE_CHECKER, 16'h1111, 16'h2222, 16'h3333, 16'hCCCC, 16'hDDDD, 16'hEEEE, 16'hFFFF);
    send_beat(32'h7FFF_0001, 32'h8000_0000, 32'h0001_0000);

    for (int p = 0; p < 12; p++) begin
      m = pattern_mode_t'(p % 4);
      case ($urandom_range(0, 3))
        0: nu = NUDGE_RST;
        1: nu = '0;
        2: nu = '1;
        default: nu = 16'($urandom);
      endcase
      if (p < 4) begin
        apply(m, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      end else if (p < 8) begin
        apply(m, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      end else begin
        apply(m, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), nu);
      end
      steady = (p == 9);
      for (int k = 0; k < 63; k++) begin
        if ((p == 6 && k == 31) || $urandom_range(0, 99) == 0) drain();
        x = pick_coord();
        y = pick_coord();
        z = pick_coord();
        if (m == MODE_RING && $urandom_range(0, 3) == 0) z = '0;
        send_beat(x, y, z);
      end
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d coordinate beats over %0d register settings covering all four patterns",
             beats, loads);
    $display("Compared %0d colour results against the predicted colours", compared);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ppc_pkg.sv
rtl/core/procedural_pattern_color.sv
rtl/core/ppc_checker.sv
tb/ppc_colour_checker.sv
tb/tb.sv
